/* hw/rtl/pfa_pkg.sv */
// Package for the physical frame allocator.
// Holds the request classes, status codes, register indexes and queue entry type.
// No dependencies.
package pfa_pkg;

    localparam int WORD_BITS = 32;
    localparam int WORD_SEL  = 5;

    localparam logic [2:0] REQ_ALLOC      = 3'd0;
    localparam logic [2:0] REQ_FREE       = 3'd1;
    localparam logic [2:0] REQ_RESERVE    = 3'd2;
    localparam logic [2:0] REQ_ALLOC_HALF = 3'd3;
    localparam logic [2:0] REQ_FREE_HALF  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    localparam logic [1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] CFG_VM_ENABLED  = 2'd1;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_RESERVE,
        OP_ALLOC_HALF,
        OP_FREE_HALF,
        OP_BAD
    } op_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCAN,
        BK_RMW
    } bk_state_t;

    typedef struct packed {
        op_t        op;
        logic [9:0] idx;
        logic       half;
    } q_entry_t;

endpackage

/* hw/rtl/pfa_front.sv */
// Front end of the frame allocator: accepts requests and classifies them.
// Uses pfa_pkg; feeds pfa_queue.
module pfa_front #(
    parameter int MAX_FRAMES = 1024
) (
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [2:0]                      req_type,
    input  logic [9:0]                      frame_index,
    input  logic                            half_select,
    input  logic [$clog2(MAX_FRAMES+1)-1:0] frame_count,
    input  logic                            clearing,
    input  logic                            q_full,
    output logic                            push,
    output pfa_pkg::q_entry_t               entry
);

    logic in_range;

    assign in_range = 32'(frame_index) < 32'(frame_count);
    assign in_stall = clearing || q_full;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        entry.idx  = frame_index;
        entry.half = half_select;
        unique case (req_type)
            pfa_pkg::REQ_ALLOC:      entry.op = pfa_pkg::OP_ALLOC;
            pfa_pkg::REQ_ALLOC_HALF: entry.op = pfa_pkg::OP_ALLOC_HALF;
            pfa_pkg::REQ_FREE:
                entry.op = in_range ? pfa_pkg::OP_FREE : pfa_pkg::OP_BAD;
            pfa_pkg::REQ_RESERVE:
                entry.op = in_range ? pfa_pkg::OP_RESERVE : pfa_pkg::OP_BAD;
            pfa_pkg::REQ_FREE_HALF:
                entry.op = in_range ? pfa_pkg::OP_FREE_HALF : pfa_pkg::OP_BAD;
            default:                 entry.op = pfa_pkg::OP_BAD;
        endcase
    end

endmodule

/* hw/rtl/pfa_queue.sv */
// Two-entry queue between the front end and the back end of the frame allocator.
// Uses pfa_pkg for the entry type.
module pfa_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pfa_pkg::q_entry_t push_entry,
    output logic              full,
    output logic              q_valid,
    input  logic              pop,
    output pfa_pkg::q_entry_t head
);

    pfa_pkg::q_entry_t slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;

    assign full    = cnt_reg == 2'd2;
    assign q_valid = cnt_reg != 2'd0;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* hw/rtl/pfa_back.sv */
// Back end of the frame allocator: bitmap memory, word scan and result register.
// Uses pfa_pkg; takes requests from pfa_queue.
module pfa_back #(
    parameter int MAX_FRAMES     = 1024,
    parameter int RESERVED_FLOOR = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [$clog2(MAX_FRAMES+1)-1:0] frame_count,
    input  logic                            vm_enabled,
    input  logic                            clear_start,
    output logic                            clearing,
    input  logic                            q_valid,
    input  pfa_pkg::q_entry_t               head,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [9:0]                      result_frame,
    output logic                            result_half,
    output logic [1:0]                      status,
    output logic [10:0]                     free_frames_left
);

    localparam int CW  = $clog2(MAX_FRAMES + 1);
    localparam int NW  = (MAX_FRAMES + pfa_pkg::WORD_BITS - 1) / pfa_pkg::WORD_BITS;
    localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int IXW = AW + pfa_pkg::WORD_SEL;
    localparam int MW  = 3 * pfa_pkg::WORD_BITS;

    // Each memory word holds frame, first-half and second-half flags of 32 frames.
    logic [MW-1:0] mem [NW];
    logic [MW-1:0] rd_word_reg;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [MW-1:0] mem_wdata;

    pfa_pkg::bk_state_t state_reg, state_next;
    logic [AW-1:0]      clr_ptr_reg, clr_ptr_next;
    logic [AW-1:0]      scan_word_reg, scan_word_next;
    pfa_pkg::op_t       cur_op_reg, cur_op_next;
    logic [IXW-1:0]     cur_fi_reg, cur_fi_next;
    logic               cur_half_reg, cur_half_next;
    logic [CW-1:0]      free_total_reg, free_total_next;
    logic               spare_valid_reg, spare_valid_next;
    logic [IXW-1:0]     spare_frame_reg, spare_frame_next;
    logic               out_valid_reg, out_valid_next;
    logic [9:0]         out_frame_reg, out_frame_next;
    logic               out_half_reg, out_half_next;
    logic [1:0]         out_status_reg, out_status_next;

    logic [31:0]                   start32, count32, base32;
    logic [pfa_pkg::WORD_BITS-1:0] avail, w_ff, w_f1, w_f2;
    logic                          hit, out_free;
    logic [pfa_pkg::WORD_SEL-1:0]  hbit, rbit;
    logic [IXW-1:0]                head_fi, hit_fi;

    assign clearing         = state_reg == pfa_pkg::BK_CLEAR;
    assign out_valid        = out_valid_reg;
    assign result_frame     = out_frame_reg;
    assign result_half      = out_half_reg;
    assign status           = out_status_reg;
    assign free_frames_left = 11'(free_total_reg);

    assign out_free = !out_valid_reg || !out_stall;
    assign start32  = vm_enabled ? 32'd0 : 32'(RESERVED_FLOOR);
    assign count32  = 32'(frame_count);
    assign base32   = 32'(scan_word_reg) << pfa_pkg::WORD_SEL;
    assign w_ff     = rd_word_reg[pfa_pkg::WORD_BITS-1:0];
    assign w_f1     = rd_word_reg[2*pfa_pkg::WORD_BITS-1:pfa_pkg::WORD_BITS];
    assign w_f2     = rd_word_reg[MW-1:2*pfa_pkg::WORD_BITS];
    assign head_fi  = IXW'(head.idx);
    assign rbit     = cur_fi_reg[pfa_pkg::WORD_SEL-1:0];
    assign hit_fi   = {scan_word_reg, hbit};

    // First free frame in the current word that lies inside [start, count).
    always_comb
    begin
        hit  = 1'b0;
        hbit = '0;
        for (int b = 0; b < pfa_pkg::WORD_BITS; b++)
            avail[b] = w_ff[b] && ((base32 | 32'(b)) >= start32)
                       && ((base32 | 32'(b)) < count32);
        for (int b = pfa_pkg::WORD_BITS - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                hit  = 1'b1;
                hbit = pfa_pkg::WORD_SEL'(b);
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_ptr_next     = clr_ptr_reg;
        scan_word_next   = scan_word_reg;
        cur_op_next      = cur_op_reg;
        cur_fi_next      = cur_fi_reg;
        cur_half_next    = cur_half_reg;
        free_total_next  = free_total_reg;
        spare_valid_next = spare_valid_reg;
        spare_frame_next = spare_frame_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_frame_next   = out_frame_reg;
        out_half_next    = out_half_reg;
        out_status_next  = out_status_reg;
        pop              = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = clr_ptr_reg;
        mem_wdata        = '1;
        mem_re           = 1'b0;
        mem_raddr        = scan_word_reg;

        unique case (state_reg)
            pfa_pkg::BK_CLEAR:
            begin
                // The frame count register already holds the newly written value here.
                free_total_next = frame_count;
                mem_we       = 1'b1;
                clr_ptr_next = clr_ptr_reg + AW'(1);
                if (clr_ptr_reg == AW'(NW - 1))
                    state_next = pfa_pkg::BK_IDLE;
            end
            pfa_pkg::BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    pop             = 1'b1;
                    cur_op_next     = head.op;
                    cur_fi_next     = head_fi;
                    cur_half_next   = head.half;
                    out_frame_next  = head.idx;
                    out_half_next   = 1'b0;
                    out_status_next = pfa_pkg::ST_OK;
                    case (head.op)
                        pfa_pkg::OP_BAD:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = pfa_pkg::ST_BAD;
                        end
                        pfa_pkg::OP_ALLOC, pfa_pkg::OP_ALLOC_HALF:
                        begin
                            if (head.op == pfa_pkg::OP_ALLOC_HALF && spare_valid_reg)
                            begin
                                out_valid_next   = 1'b1;
                                out_frame_next   = 10'(spare_frame_reg);
                                out_half_next    = 1'b1;
                                spare_valid_next = 1'b0;
                            end
                            else if (start32 >= count32)
                            begin
                                out_valid_next  = 1'b1;
                                out_frame_next  = '0;
                                out_status_next = pfa_pkg::ST_NOFREE;
                            end
                            else
                            begin
                                mem_re         = 1'b1;
                                mem_raddr      = AW'(start32 >> pfa_pkg::WORD_SEL);
                                scan_word_next = mem_raddr;
                                state_next     = pfa_pkg::BK_SCAN;
                            end
                        end
                        default:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = head_fi[IXW-1:pfa_pkg::WORD_SEL];
                            state_next = pfa_pkg::BK_RMW;
                        end
                    endcase
                end
            end
            pfa_pkg::BK_SCAN:
            begin
                if (hit)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = scan_word_reg;
                    mem_wdata       = rd_word_reg & ~{3{pfa_pkg::WORD_BITS'(1) << hbit}};
                    free_total_next = free_total_reg - CW'(1);
                    out_valid_next  = 1'b1;
                    out_frame_next  = 10'(hit_fi);
                    out_half_next   = 1'b0;
                    if (cur_op_reg == pfa_pkg::OP_ALLOC_HALF)
                    begin
                        spare_valid_next = 1'b1;
                        spare_frame_next = hit_fi;
                    end
                    state_next = pfa_pkg::BK_IDLE;
                end
                else if ((base32 + 32'(pfa_pkg::WORD_BITS)) < count32)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = scan_word_reg + AW'(1);
                    scan_word_next = mem_raddr;
                end
                else
                begin
                    out_valid_next  = 1'b1;
                    out_frame_next  = '0;
                    out_status_next = pfa_pkg::ST_NOFREE;
                    state_next      = pfa_pkg::BK_IDLE;
                end
            end
            pfa_pkg::BK_RMW:
            begin
                mem_waddr      = cur_fi_reg[IXW-1:pfa_pkg::WORD_SEL];
                mem_wdata      = rd_word_reg;
                out_valid_next = 1'b1;
                state_next     = pfa_pkg::BK_IDLE;
                case (cur_op_reg)
                    pfa_pkg::OP_RESERVE:
                    begin
                        if (w_ff[rbit])
                        begin
                            mem_we          = 1'b1;
                            mem_wdata       = rd_word_reg
                                              & ~{3{pfa_pkg::WORD_BITS'(1) << rbit}};
                            free_total_next = free_total_reg - CW'(1);
                        end
                    end
                    pfa_pkg::OP_FREE:
                    begin
                        if (w_ff[rbit])
                            out_status_next = pfa_pkg::ST_BAD;
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_wdata       = rd_word_reg
                                              | {3{pfa_pkg::WORD_BITS'(1) << rbit}};
                            free_total_next = free_total_reg + CW'(1);
                            if (spare_frame_reg == cur_fi_reg)
                                spare_valid_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        // Free half: the frame comes back once its other half is free too.
                        if (w_ff[rbit] || (cur_half_reg ? w_f2[rbit] : w_f1[rbit]))
                            out_status_next = pfa_pkg::ST_BAD;
                        else
                        begin
                            mem_we = 1'b1;
                            if (cur_half_reg)
                                mem_wdata[2*pfa_pkg::WORD_BITS + 32'(rbit)] = 1'b1;
                            else
                                mem_wdata[pfa_pkg::WORD_BITS + 32'(rbit)] = 1'b1;
                            if (cur_half_reg ? w_f1[rbit] : w_f2[rbit])
                            begin
                                mem_wdata[rbit] = 1'b1;
                                free_total_next = free_total_reg + CW'(1);
                                if (spare_frame_reg == cur_fi_reg)
                                    spare_valid_next = 1'b0;
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = pfa_pkg::BK_CLEAR;
            end
        endcase

        if (clear_start)
        begin
            state_next       = pfa_pkg::BK_CLEAR;
            clr_ptr_next     = '0;
            spare_valid_next = 1'b0;
            spare_frame_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pfa_pkg::BK_CLEAR;
            clr_ptr_reg     <= '0;
            free_total_reg  <= CW'(MAX_FRAMES);
            spare_valid_reg <= 1'b0;
            spare_frame_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_ptr_reg     <= clr_ptr_next;
            free_total_reg  <= free_total_next;
            spare_valid_reg <= spare_valid_next;
            spare_frame_reg <= spare_frame_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_word_reg  <= scan_word_next;
        cur_op_reg     <= cur_op_next;
        cur_fi_reg     <= cur_fi_next;
        cur_half_reg   <= cur_half_next;
        out_frame_reg  <= out_frame_next;
        out_half_reg   <= out_half_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_word_reg <= mem[mem_raddr];
    end

    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(free_total_reg) <= MAX_FRAMES)
        else $error("free frame count above capacity");

    a_spare_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        spare_valid_reg |-> (32'(spare_frame_reg) < count32))
        else $error("spare half held on a frame outside the frame count");

    a_rmw_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfa_pkg::BK_RMW) |-> ($past(state_reg) == pfa_pkg::BK_IDLE))
        else $error("read-modify-write entered without a dequeue");

endmodule

/* hw/rtl/physical_frame_allocator.sv */
// A request is queued at acceptance and dequeued once the back end is idle and its result
// register is free; a bad request or a held spare half is answered from the dequeue itself,
// free/reserve/free-half after a read of its bitmap word, and an allocation after a scan of
// 32-frame bitmap words from the start word. The back end handles one transaction at a
// time; the word scan sets the rate. Reset and every frame_count write start a clearing
// pass over the bitmap words during which no transaction is accepted.
module physical_frame_allocator #(
    parameter int MAX_FRAMES     = 1024,
    parameter int RESERVED_FLOOR = 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [9:0]  frame_index,
    input  logic        half_select,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  result_frame,
    output logic        result_half,
    output logic [1:0]  status,
    output logic [10:0] free_frames_left
);

    localparam int CW = $clog2(MAX_FRAMES + 1);

    logic [CW-1:0]     frame_count_reg, frame_count_next;
    logic              vm_reg, vm_next;
    logic              clear_start, clearing, q_full, q_valid, push, pop;
    pfa_pkg::q_entry_t push_entry, head;

    assign cfg_ready   = 1'b1;
    assign clear_start = cfg_valid && (cfg_index == pfa_pkg::CFG_FRAME_COUNT);

    always_comb
    begin
        frame_count_next = frame_count_reg;
        vm_next          = vm_reg;
        if (clear_start)
            frame_count_next = (32'(cfg_data) > MAX_FRAMES) ? CW'(MAX_FRAMES) : CW'(cfg_data);
        if (cfg_valid && (cfg_index == pfa_pkg::CFG_VM_ENABLED))
            vm_next = cfg_data[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= CW'(MAX_FRAMES);
            vm_reg          <= 1'b0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
            vm_reg          <= vm_next;
        end
    end

    pfa_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .frame_index (frame_index),
        .half_select (half_select),
        .frame_count (frame_count_reg),
        .clearing    (clearing),
        .q_full      (q_full),
        .push        (push),
        .entry       (push_entry)
    );

    pfa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .pop        (pop),
        .head       (head)
    );

    pfa_back #(
        .MAX_FRAMES     (MAX_FRAMES),
        .RESERVED_FLOOR (RESERVED_FLOOR)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .frame_count      (frame_count_reg),
        .vm_enabled       (vm_reg),
        .clear_start      (clear_start),
        .clearing         (clearing),
        .q_valid          (q_valid),
        .head             (head),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_frame     (result_frame),
        .result_half      (result_half),
        .status           (status),
        .free_frames_left (free_frames_left)
    );

endmodule
